### hw/rtl/ppc_pkg.sv
// ============================================================================
// ppc_pkg
// Shared types and constants for the page permission classifier.
// ============================================================================
package ppc_pkg;

    localparam int ROW_IDX_W = 4;
    localparam int ADDR_BITS = 32;
    localparam int PAGE_W    = 20;
    localparam int HIGH_W    = 21;
    localparam int PERM_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    localparam logic [PERM_W-1:0] PERM_UNAVAILABLE = 2'd0;
    localparam logic [PERM_W-1:0] PERM_RESERVED    = 2'd1;
    localparam logic [PERM_W-1:0] PERM_FREE        = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_USER_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_HIGH = 1'd1;

    // window edges after reset: byte 0x40000000 and byte 0xF0000000 in 4 KiB pages
    localparam logic [PAGE_W-1:0] USER_LOW_RESET  = 20'h40000;
    localparam logic [HIGH_W-1:0] USER_HIGH_RESET = 21'h0F0000;

    typedef struct packed {
        logic                 usable;
        logic [ADDR_BITS:0]   span_end;
        logic [ADDR_BITS-1:0] span_start;
    } ppc_row_t;

    typedef struct packed {
        logic load_we;
        logic q_start;
        logic scan_rd;
        logic out_load;
    } ppc_cmd_t;

    typedef struct packed {
        logic q_short;
        logic scan_last;
        logic out_space;
    } ppc_sts_t;

endpackage

### hw/rtl/ppc_ctrl.sv
// ============================================================================
// ppc_ctrl
// Sequencer: takes items, steps the row scan, hands results to the output.
// ============================================================================
module ppc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_kind,
    output logic               in_ready,
    output ppc_pkg::ppc_cmd_t  cmd,
    input  ppc_pkg::ppc_sts_t  sts
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == ppc_pkg::KIND_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.q_start = 1'b1;
                        state_next  = sts.q_short ? ST_OUT : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_space)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ppc_dp.sv
// ============================================================================
// ppc_dp
// Datapath: window registers, range row memory, containment compare, output.
// ============================================================================
module ppc_dp #(
    parameter int MAX_ROWS   = 16,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppc_pkg::ppc_cmd_t                    cmd,
    output ppc_pkg::ppc_sts_t                    sts,
    input  logic                                 cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppc_pkg::HIGH_W-1:0]           cfg_data,
    input  logic [ppc_pkg::ROW_IDX_W-1:0]        row_index,
    input  logic [ppc_pkg::ADDR_BITS-1:0]        range_start,
    input  logic [ppc_pkg::ADDR_BITS-1:0]        range_length,
    input  logic                                 range_usable,
    input  logic                                 last_row,
    input  logic [ppc_pkg::PAGE_W-1:0]           lookup_page,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ppc_pkg::PAGE_W-1:0]           page_number,
    output logic [ppc_pkg::PERM_W-1:0]           permission
);

    localparam int AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int PG_W   = ppc_pkg::PAGE_W + PAGE_SHIFT + 1;
    localparam int CMP_W  = (PG_W > ppc_pkg::ADDR_BITS + 1) ? PG_W : ppc_pkg::ADDR_BITS + 1;

    logic [ppc_pkg::PAGE_W-1:0] user_low_reg;
    logic [ppc_pkg::HIGH_W-1:0] user_high_reg;
    logic [CNT_W-1:0]           row_count_reg;
    logic [AW-1:0]              scan_idx_reg;
    logic                       rd_vld_reg;
    ppc_pkg::ppc_row_t          rd_data_reg;
    ppc_pkg::ppc_row_t          row_mem [MAX_ROWS];
    logic [ppc_pkg::PAGE_W-1:0] page_reg;
    logic [CMP_W-1:0]           pbase_reg;
    logic [CMP_W-1:0]           pend_reg;
    logic                       reserved_reg;
    logic                       hit_reg;
    logic                       out_valid_reg;
    logic [ppc_pkg::PAGE_W-1:0] out_page_reg;
    logic [ppc_pkg::PERM_W-1:0] out_perm_reg;

    logic                       row_ok;
    logic [AW-1:0]              wr_addr;
    ppc_pkg::ppc_row_t          wr_row;
    logic                       reserved;
    logic                       row_hit;

    assign row_ok  = int'(row_index) < MAX_ROWS;
    assign wr_addr = AW'(row_index);

    always_comb
    begin
        wr_row.usable     = range_usable;
        wr_row.span_start = range_start;
        wr_row.span_end   = {1'b0, range_start} + {1'b0, range_length};
    end

    assign reserved = (lookup_page < user_low_reg)
                   || (ppc_pkg::HIGH_W'(lookup_page) >= user_high_reg);

    assign row_hit = rd_vld_reg && rd_data_reg.usable
                  && (CMP_W'(rd_data_reg.span_start) <= pbase_reg)
                  && (pend_reg <= CMP_W'(rd_data_reg.span_end));

    always_comb
    begin
        sts.q_short   = reserved || (row_count_reg == '0);
        sts.scan_last = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == row_count_reg;
        sts.out_space = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_low_reg  <= ppc_pkg::USER_LOW_RESET;
            user_high_reg <= ppc_pkg::USER_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppc_pkg::CFG_USER_LOW:  user_low_reg  <= cfg_data[ppc_pkg::PAGE_W-1:0];
                ppc_pkg::CFG_USER_HIGH: user_high_reg <= cfg_data;
                default:                user_high_reg <= user_high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.load_we && row_ok && last_row)
            begin
                row_count_reg <= CNT_W'({1'b0, row_index} + 5'd1);
            end
            if (cmd.q_start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
            end
            if (cmd.q_start)
            begin
                hit_reg <= 1'b0;
            end
            else if (row_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // row memory: one write port for loads, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && row_ok)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        rd_data_reg <= row_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            page_reg     <= lookup_page;
            reserved_reg <= reserved;
            pbase_reg    <= CMP_W'(lookup_page) << PAGE_SHIFT;
            pend_reg     <= (CMP_W'(lookup_page) + CMP_W'(1)) << PAGE_SHIFT;
        end
        if (cmd.out_load)
        begin
            out_page_reg <= page_reg;
            if (reserved_reg)
            begin
                out_perm_reg <= ppc_pkg::PERM_RESERVED;
            end
            else if (hit_reg)
            begin
                out_perm_reg <= ppc_pkg::PERM_FREE;
            end
            else
            begin
                out_perm_reg <= ppc_pkg::PERM_UNAVAILABLE;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign page_number = out_page_reg;
    assign permission  = out_perm_reg;

endmodule

### hw/rtl/page_permission_classifier.sv
// ============================================================================
// page_permission_classifier
// Memory-map range table with per-page permission lookup.
// ============================================================================
// A load item (tuser 0) writes one range row; tlast on a load sets
// the row count to row_index + 1. A query item (tuser 1) returns one result:
// reserved when the page is outside [user_low_page, user_high_page), else free
// when one usable row holds the whole page, else unavailable. A query outside
// the window or against an empty table skips the row scan; otherwise the scan
// walks all row_count rows through the row memory's single read port, one row
// per cycle. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken.
module page_permission_classifier #(
    parameter int MAX_ROWS   = 16,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row_index[3:0], range_start[35:4], range_length[67:36],
    // range_usable[68], lookup_page[88:69], zero[95:89]
    input  logic [ppc_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[0]
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // page_number[19:0], permission[21:20], zero[23:22]
    output logic [ppc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppc_pkg::HIGH_W-1:0]        cfg_data
);

    ppc_pkg::ppc_cmd_t          cmd;
    ppc_pkg::ppc_sts_t          sts;
    logic [ppc_pkg::PAGE_W-1:0] page_number;
    logic [ppc_pkg::PERM_W-1:0] permission;

    assign cfg_ready = 1'b1;

    ppc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ppc_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .row_index    (s_tdata[3:0]),
        .range_start  (s_tdata[35:4]),
        .range_length (s_tdata[67:36]),
        .range_usable (s_tdata[68]),
        .last_row     (s_tlast),
        .lookup_page  (s_tdata[88:69]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .page_number  (page_number),
        .permission   (permission)
    );

    assign m_tdata = {2'b00, permission, page_number};

`ifndef SYNTHESIS
    a_perm_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (permission == ppc_pkg::PERM_UNAVAILABLE
                   || permission == ppc_pkg::PERM_RESERVED
                   || permission == ppc_pkg::PERM_FREE))
        else $error("result with undefined permission code");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == ppc_pkg::KIND_QUERY) |=> !s_tready)
        else $error("item taken while a query is in flight");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == ppc_pkg::KIND_LOAD && !m_tvalid) |=> !m_tvalid)
        else $error("load item produced a result");
`endif

endmodule
